// ----- hdl/cefl_pkg.sv -----
// Shared types and constants of the clamped-edge FIR line filter.
package cefl_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COEF_W = 16;
	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int NUM_COEF = 7;
	localparam int MAX_TAPS = 7;
	localparam int TREE_LEAVES = 8;
	localparam int SUM_W = PROD_W + 3;
	localparam int ROUND_SHIFT = 15;
	localparam logic [SUM_W-1:0] ROUND_BIAS = SUM_W'(16384);

	typedef logic [SAMPLE_W-1:0] sample_t;
	typedef logic [COEF_W-1:0] coef_t;
	typedef logic [PROD_W-1:0] prod_t;

	// Reset value of the coefficient registers: identity filter
	localparam coef_t COEF_RESET [NUM_COEF] = '{
		16'd0, 16'd0, 16'd0, 16'd32768, 16'd0, 16'd0, 16'd0
	};

	// Per-cell control: shift the chain, clear the in-line mark, capture a product
	typedef struct packed {
		logic shift;
		logic clear;
		logic capture;
	} cell_ctl_t;

endpackage

// ----- hdl/cefl_cell.sv -----
// One cell of the sample chain: holds a sample, its in-line mark and one tap product.
module cefl_cell
	import cefl_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  sample_t   data_in,
	input  logic      inline_in,
	input  coef_t     coef,
	input  sample_t   first,
	output sample_t   data_q,
	output logic      inline_q,
	output prod_t     prod_s1
);

	sample_t operand;

	// Advance the sample and its mark from the neighbor
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data_q <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inline_q <= 1'b0;
		end else if (ctl.shift) begin
			inline_q <= inline_in & ~ctl.clear;
		end
	end

	// Replace samples from before the line with the line's first sample
	assign operand = inline_q ? data_q : first;

	// Weight the sample by this tap
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			prod_s1 <= {{SAMPLE_W{1'b0}}, coef} * {{COEF_W{1'b0}}, operand};
		end
	end

endmodule

// ----- hdl/cefl_sum.sv -----
// Registered adder tree with rounding, saturation and the output register.
module cefl_sum
	import cefl_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	input  prod_t         prods [TREE_LEAVES],
	input  logic          in_valid,
	input  logic          in_last,
	output logic          in_ready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [15:0]   m_tdata,   // [15:0] pixel_out
	output logic          m_tlast    // line_end_out
);

	logic [PROD_W:0]   pair_s2 [4];
	logic [PROD_W+1:0] quad_s3 [2];
	logic              v2_s2, v3_s3;
	logic              last_s2, last_s3;
	logic              rdy2, rdy3, rdy_o;
	logic [SUM_W-1:0]  total;
	logic [SUM_W-ROUND_SHIFT-1:0] scaled;

	assign rdy_o = ~m_tvalid | m_tready;
	assign rdy3 = ~v3_s3 | rdy_o;
	assign rdy2 = ~v2_s2 | rdy3;
	assign in_ready = rdy2;

	// Add product pairs
	always_ff @(posedge clk) begin
		if (rdy2) begin
			for (int i = 0; i < 4; i++) begin
				pair_s2[i] <= (PROD_W+1)'(prods[2*i]) + (PROD_W+1)'(prods[2*i+1]);
			end
			last_s2 <= in_last;
		end
	end

	// Add pair sums
	always_ff @(posedge clk) begin
		if (rdy3) begin
			for (int i = 0; i < 2; i++) begin
				quad_s3[i] <= (PROD_W+2)'(pair_s2[2*i]) + (PROD_W+2)'(pair_s2[2*i+1]);
			end
			last_s3 <= last_s2;
		end
	end

	// Round, drop the fraction bits and clamp to the sample range
	assign total = SUM_W'(quad_s3[0]) + SUM_W'(quad_s3[1]) + ROUND_BIAS;
	assign scaled = total[SUM_W-1:ROUND_SHIFT];

	always_ff @(posedge clk) begin
		if (rdy_o) begin
			m_tdata <= (|scaled[SUM_W-ROUND_SHIFT-1:SAMPLE_W]) ? {SAMPLE_W{1'b1}}
				: scaled[SAMPLE_W-1:0];
			m_tlast <= last_s3;
		end
	end

	// Stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			m_tvalid <= 1'b0;
		end else begin
			if (rdy2) v2_s2 <= in_valid;
			if (rdy3) v3_s3 <= v2_s2;
			if (rdy_o) m_tvalid <= v3_s3;
		end
	end

endmodule

// ----- hdl/clamped_edge_fir_line_filter.sv -----
// Top level of the clamped-edge FIR line filter: APB registers, chain of cells, flush control.
//
// Channel   Dir  Handshake                 Payload
// s_*       in   s_tvalid / s_tready       s_tdata[15:0] pixel_in, s_tlast line_end_in
// m_*       out  m_tvalid / m_tready       m_tdata[15:0] pixel_out, m_tlast line_end_out
// APB       in   psel, penable, pready=1   coef_0..coef_6 at byte address 4*i
//
// One pixel is accepted per cycle while s_tready is high. After a pixel with s_tlast,
// the chain is fed TAP_COUNT/2 copies of the last pixel, and s_tready is low while
// they are fed. A result passes the chain, tap products, two adder levels, and
// rounding into the output register.
// Reset clears the chain marks and pipeline flags and loads the identity filter.
// A stall on m_tready fills the pipeline stages first; outside a flush, s_tready
// drops only when the chain holds a pending result that cannot move on.
module clamped_edge_fir_line_filter
	import cefl_pkg::*;
#(
	parameter int TAP_COUNT = 7
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] pixel_in
	input  logic        s_tlast,   // line_end_in
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] pixel_out
	output logic        m_tlast,   // line_end_out
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int HALF = TAP_COUNT / 2;
	localparam int DW = (HALF > 0) ? $clog2(HALF + 1) : 1;
	localparam int PREV = (HALF > 0) ? HALF - 1 : 0;

	typedef enum logic [1:0] {
		ST_RUN   = 2'b01,
		ST_FLUSH = 2'b10
	} state_t;

	state_t          st_q;
	logic [DW-1:0]   dup_q;
	logic            fresh_q;
	sample_t         first_q;
	coef_t           coef_q [NUM_COEF];
	logic            ev_q, ev_last_q;
	logic            v1_s1, last_s1;
	logic            rdy0, rdy1, sum_ready;
	logic            flushing, in_push, dup_push, push, last_dup, clear;
	logic            emit, emit_last, line_done;
	logic [2:0]      idx;
	sample_t         shift_data;
	sample_t         dat [TAP_COUNT];
	logic            inl [TAP_COUNT];
	prod_t           prod_cell [TAP_COUNT];
	prod_t           prod_all [TREE_LEAVES];

	// Register file
	assign pready = 1'b1;
	assign idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_COEF; i++) coef_q[i] <= COEF_RESET[i];
		end else if (psel && penable && pwrite && pready) begin
			for (int i = 0; i < NUM_COEF; i++) begin
				if (idx == 3'(i)) coef_q[i] <= pwdata[COEF_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < NUM_COEF; i++) begin
			if (idx == 3'(i)) prdata = {{(32-COEF_W){1'b0}}, coef_q[i]};
		end
	end

	// Push control: new pixels, or copies of the last pixel while flushing
	assign rdy1 = ~v1_s1 | sum_ready;
	assign rdy0 = ~ev_q | rdy1;
	assign flushing = (st_q == ST_FLUSH);
	assign s_tready = rdy0 & ~flushing;
	assign in_push = s_tvalid & s_tready;
	assign dup_push = flushing & rdy0;
	assign push = in_push | dup_push;
	assign last_dup = dup_push && (dup_q == DW'(HALF - 1));
	assign clear = in_push & fresh_q;
	assign shift_data = flushing ? dat[0] : s_tdata;
	assign line_done = (HALF == 0) ? (in_push & s_tlast) : last_dup;

	// A result is due when the center cell holds a sample of the line after the push
	assign emit = (HALF == 0) ? 1'b1 : (~clear & inl[PREV]);
	assign emit_last = line_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_RUN;
			dup_q <= '0;
			fresh_q <= 1'b1;
		end else begin
			case (st_q)
				ST_RUN: begin
					if (in_push && s_tlast && (HALF > 0)) begin
						st_q <= ST_FLUSH;
						dup_q <= '0;
					end
				end
				ST_FLUSH: begin
					if (dup_push) begin
						dup_q <= DW'(dup_q + 1'b1);
						if (last_dup) st_q <= ST_RUN;
					end
				end
				default: st_q <= ST_RUN;
			endcase
			if (line_done) fresh_q <= 1'b1;
			else if (in_push) fresh_q <= 1'b0;
		end
	end

	// Hold the line's first pixel for the left border
	always_ff @(posedge clk) begin
		if (clear) first_q <= s_tdata;
	end

	// Pending request on the current chain contents
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_q <= 1'b0;
			v1_s1 <= 1'b0;
		end else begin
			if (rdy0) ev_q <= push & emit;
			if (rdy1) v1_s1 <= ev_q;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy0) ev_last_q <= emit_last;
		if (rdy1) last_s1 <= ev_last_q;
	end

	// Chain of cells, newest sample in cell 0
	for (genvar k = 0; k < TAP_COUNT; k++) begin : g_cell
		cell_ctl_t ctl;
		sample_t   din;
		logic      iin;

		if (k == 0) begin : g_head
			assign din = shift_data;
			assign iin = 1'b1;
			assign ctl = '{shift: push, clear: 1'b0, capture: ev_q & rdy1};
		end else begin : g_body
			assign din = dat[k-1];
			assign iin = inl[k-1];
			assign ctl = '{shift: push, clear: clear, capture: ev_q & rdy1};
		end

		cefl_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.data_in  (din),
			.inline_in(iin),
			.coef     (coef_q[k]),
			.first    (first_q),
			.data_q   (dat[k]),
			.inline_q (inl[k]),
			.prod_s1  (prod_cell[k])
		);
	end

	// Pad unused leaves of the adder tree with zero
	always_comb begin
		for (int i = 0; i < TREE_LEAVES; i++) begin
			prod_all[i] = (i < TAP_COUNT) ? prod_cell[(i < TAP_COUNT) ? i : 0] : '0;
		end
	end

	cefl_sum u_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.prods    (prod_all),
		.in_valid (v1_s1),
		.in_last  (last_s1),
		.in_ready (sum_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// No new pixel enters while the chain is being flushed
	a_flush_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		flushing |-> !s_tready)
		else $error("pixel accepted during line flush");

	// A pending request that cannot move on is kept
	a_request_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(ev_q && !rdy1) |=> ev_q)
		else $error("pending request dropped");

	// The final copy of a flush opens the next line
	a_flush_ends_line: assert property (@(posedge clk) disable iff (!arst_n)
		last_dup |=> (fresh_q && (st_q == ST_RUN)))
		else $error("flush did not end the line");

	// The first pixel of a line is kept as border value and marks cell 0
	a_first_kept: assert property (@(posedge clk) disable iff (!arst_n)
		clear |=> (inl[0] && (first_q == $past(s_tdata))))
		else $error("first pixel of the line not captured");

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the clamped-edge FIR line filter: directed table, random lines, output scoreboard.
`timescale 1ns / 1ps

module tb_top
	import cefl_pkg::*;
;

	localparam int TAP_COUNT = 7;
	localparam int HALF = TAP_COUNT / 2;
	localparam int WIN_DEPTH = 7;
	localparam int COEF_ADDR_STRIDE = 4;
	localparam int DRAIN_CYCLES = 12;
	localparam int LONG_HOLD = 80;
	localparam int QUIET_LIMIT = 1000;
	localparam int LINE_ITEMS = 60;
	localparam int SHOWN_MISMATCHES = 10;

	typedef enum logic {ROW_PIXEL, ROW_COEFS} row_kind_t;
	typedef enum logic [1:0] {TAPS_SMOOTH, TAPS_WILD, TAPS_EXTREME, TAPS_SINGLE} taps_style_t;

	typedef struct packed {
		row_kind_t kind;
		logic [15:0] value;
		logic last;
		logic typed;
		logic [15:0] want;
	} step_row_t;

	typedef struct packed {
		sample_t pixel;
		logic last;
	} filtered_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;   // [15:0] pixel_in
	logic s_tlast = 1'b0;        // line_end_in
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;        // [15:0] pixel_out
	logic m_tlast;               // line_end_out
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [4:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// Filter state mirrored on the bench side
	coef_t tap_weight [NUM_COEF];
	sample_t line_window [WIN_DEPTH];
	sample_t line_first;
	logic [2:0] line_count;
	filtered_t due_outputs[$];

	step_row_t dir_rows[$];
	logic typed_due = 1'b0;
	sample_t typed_px = '0;
	int send_gap_pct = 0;
	int recv_gap_pct = 0;
	logic ready_hold_due = 1'b0;
	int hold_left = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	clamped_edge_fir_line_filter #(.TAP_COUNT(TAP_COUNT)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #1 clk = ~clk;

	// Weighted sum for the output position s samples older than the newest one
	function automatic sample_t filtered_at(int s, int count);
		logic [63:0] acc;
		int age;
		sample_t v;
		acc = 64'd0;
		for (int j = 0; j < TAP_COUNT; j++) begin
			age = s - HALF + j;
			if (age < 0)
				age = 0;
			// clamp past the line's first sample
			if (age >= count || age >= WIN_DEPTH) begin
				v = line_first;
			end else begin
				v = line_window[age];
			end
			acc += 64'(tap_weight[j]) * 64'(v);
		end
		acc = (acc + 64'(ROUND_BIAS)) >> ROUND_SHIFT;
		return (acc > 64'd65535) ? 16'hFFFF : acc[15:0];
	endfunction

	// Shift one pixel into the line and queue the outputs it makes due
	task automatic advance_line(input sample_t px, input logic last);
		int count;
		int s;
		for (int i = WIN_DEPTH - 1; i > 0; i--)
			line_window[i] = line_window[i - 1];
		line_window[0] = px;
		if (line_count == 3'd0)
			line_first = px;
		if (line_count < 3'd7)
			line_count++;
		count = line_count;
		if (!last) begin
			if (count > HALF)
				due_outputs.push_back('{filtered_at(HALF, count), 1'b0});
		end else begin
			// flush every output still due, the last one marked
			s = (count > HALF) ? HALF : count - 1;
			while (s >= 0) begin
				due_outputs.push_back('{filtered_at(s, count), s == 0});
				s--;
			end
			line_count = 3'd0;
		end
	endtask

	// Offer one pixel, with random gaps ahead of it, and wait for the request to be taken
	task automatic send_pixel(input sample_t px, input logic last, input logic typed,
			input sample_t want);
		@(negedge clk);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			s_tdata <= 16'($urandom);
			s_tlast <= 1'($urandom);
			@(negedge clk);
		end
		typed_due = typed;
		typed_px = want;
		s_tvalid <= 1'b1;
		s_tdata <= px;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Hold the input until every expected output is out, then let the pipeline settle
	task automatic drain_outputs();
		@(negedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Write all seven coefficients over the register port
	task automatic load_taps(input coef_t w [NUM_COEF]);
		drain_outputs();
		for (int i = 0; i < NUM_COEF; i++) begin
			@(negedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= 5'(i * COEF_ADDR_STRIDE);
			pwdata <= 32'(w[i]);
			@(negedge clk);
			penable <= 1'b1;
			@(posedge clk);
			while (!pready)
				@(posedge clk);
			tap_weight[i] = w[i];
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Drive output ready: long hold on request, else random stalls
	always @(negedge clk) begin
		if (ready_hold_due) begin
			hold_left = LONG_HOLD;
			ready_hold_due = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// Predict on accepted requests, check accepted outputs, watch for a hang
	always @(posedge clk) begin
		filtered_t got;
		filtered_t exp_out;
		got = '{m_tdata, m_tlast};
		if (s_tvalid && s_tready) begin
			advance_line(s_tdata, s_tlast);
			// a hand-written row replaces the single output it predicts
			if (typed_due) begin
				void'(due_outputs.pop_back());
				due_outputs.push_back('{typed_px, 1'b1});
				typed_due = 1'b0;
			end
		end
		if (m_tvalid && m_tready) begin
			if (due_outputs.size() == 0) begin
				if (mismatches < SHOWN_MISMATCHES)
					$display("unexpected output pixel %h last %b", got.pixel, got.last);
				mismatches++;
			end else begin
				exp_out = due_outputs.pop_front();
				if (got != exp_out) begin
					if (mismatches < SHOWN_MISMATCHES)
						$display("mismatch: pixel exp %h got %h, last exp %b got %b",
							exp_out.pixel, got.pixel, exp_out.last, got.last);
					mismatches++;
				end
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(psel && penable && pwrite && pready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		coef_t w [NUM_COEF];
		int line_left;
		int r;
		int a;
		int b;
		int c;
		sample_t px;
		taps_style_t style;

		// Mirror the reset state
		tap_weight = COEF_RESET;
		for (int i = 0; i < WIN_DEPTH; i++)
			line_window[i] = '0;
		line_first = '0;
		line_count = 3'd0;
		line_left = 0;

		// Identity filter after reset: single-pixel lines, short lines, one long line
		dir_rows.push_back('{ROW_PIXEL, 16'h0000, 1'b1, 1'b1, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF});
		dir_rows.push_back('{ROW_PIXEL, 16'h1234, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'hABCD, 1'b1, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'h0001, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'h8000, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'h7FFF, 1'b1, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'h0000, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'hFFFF, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'h5555, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'hAAAA, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'h00FF, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'hFF00, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'h0F0F, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'hF0F0, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'h8001, 1'b1, 1'b0, 16'h0000});
		// Oversized weights saturate
		dir_rows.push_back('{ROW_COEFS, 16'hFFFF, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'hFFFF, 1'b1, 1'b1, 16'hFFFF});
		dir_rows.push_back('{ROW_PIXEL, 16'h0000, 1'b1, 1'b1, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'h0001, 1'b1, 1'b0, 16'h0000});
		// All weights zero
		dir_rows.push_back('{ROW_COEFS, 16'h0000, 1'b0, 1'b0, 16'h0000});
		dir_rows.push_back('{ROW_PIXEL, 16'hFFFF, 1'b1, 1'b1, 16'h0000});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Walk the directed table
		foreach (dir_rows[k]) begin
			if (dir_rows[k].kind == ROW_COEFS) begin
				for (int i = 0; i < NUM_COEF; i++)
					w[i] = dir_rows[k].value;
				load_taps(w);
			end else begin
				send_pixel(dir_rows[k].value, dir_rows[k].last, dir_rows[k].typed,
					dir_rows[k].want);
			end
		end

		// Random lines under three idling patterns, two weight sets each
		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 34 : (phase == 1) ? 57 : 0;
			recv_gap_pct = (phase == 0) ? 57 : (phase == 1) ? 34 : 0;
			for (int set = 0; set < 2; set++) begin
				style = taps_style_t'((phase * 2 + set) % 4);
				case (style)
					TAPS_SMOOTH: begin
						a = $urandom_range(1024);
						b = $urandom_range(4096);
						c = $urandom_range(8192);
						w[0] = coef_t'(a);
						w[6] = coef_t'(a);
						w[1] = coef_t'(b);
						w[5] = coef_t'(b);
						w[2] = coef_t'(c);
						w[4] = coef_t'(c);
						w[3] = coef_t'(32768 - 2 * (a + b + c));
					end
					TAPS_WILD: begin
						for (int i = 0; i < NUM_COEF; i++)
							w[i] = coef_t'($urandom);
					end
					TAPS_EXTREME: begin
						for (int i = 0; i < NUM_COEF; i++) begin
							r = $urandom_range(2);
							w[i] = (r == 0) ? 16'h0000 : (r == 1) ? 16'h8000 : 16'hFFFF;
						end
					end
					default: begin
						for (int i = 0; i < NUM_COEF; i++)
							w[i] = '0;
						w[$urandom_range(NUM_COEF - 1)] = 16'h8000;
					end
				endcase
				load_taps(w);
				// fill the block against a stalled output once
				if (phase == 2 && set == 0)
					ready_hold_due = 1'b1;
				for (int k = 0; k < LINE_ITEMS; k++) begin
					if (line_left == 0) begin
						r = $urandom_range(9);
						line_left = (r < 3) ? $urandom_range(1, 3) :
							(r < 9) ? $urandom_range(4, 16) : $urandom_range(17, 40);
					end
					if ($urandom_range(7) == 0) begin
						px = $urandom_range(1) ? 16'hFFFF : 16'h0000;
					end else begin
						px = 16'($urandom);
					end
					send_pixel(px, line_left == 1, 1'b0, '0);
					line_left--;
				end
			end
		end

		// Drain and report
		@(negedge clk);
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (due_outputs.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
